[design/gic_pkg.sv]
`default_nettype none

package gic_pkg;

  // Axis and hat constants
  localparam logic [14:0] AXIS_MAX     = 15'h7FFF;
  localparam logic [15:0] POV_CENTERED = 16'hFFFF;
  localparam logic [16:0] FULL_TURN    = 17'd36000;
  localparam logic [16:0] HALF_TURN    = 17'd18000;
  localparam logic [16:0] QUARTER_TURN = 17'd9000;

  // Reset values of the deadzone registers
  localparam logic [14:0] LEFT_DZ_RESET  = 15'd3924;
  localparam logic [14:0] RIGHT_DZ_RESET = 15'd4344;

  // Default pad count
  localparam int GIC_PADS = 4;

  // One stick axis: magnitude after saturation and sign of the final value
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } axis_t;

  // Work handed to the stick engine: axes 0..3 are LX, LY, RX, RY
  typedef struct packed {
    axis_t [3:0] axis;
    logic [14:0] dz_left;
    logic [14:0] dz_right;
  } stick_req_t;

  // Engine status and conditioned axes in the same order
  typedef struct packed {
    logic             done;
    logic [3:0][15:0] value;
  } eng_result_t;

endpackage

`default_nettype wire

[design/gic_poll_if.sv]
`default_nettype none

interface gic_poll_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  pad_index;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic        [11:0] buttons;
  logic        [15:0] pov_angle;

  modport source (
    output valid, pad_index, left_x, left_y, right_x, right_y, buttons, pov_angle,
    input  ready
  );

  modport sink (
    input  valid, pad_index, left_x, left_y, right_x, right_y, buttons, pov_angle,
    output ready
  );
endinterface

`default_nettype wire

[design/gic_result_if.sv]
`default_nettype none

interface gic_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out_x;
  logic signed [15:0] left_out_y;
  logic signed [15:0] right_out_x;
  logic signed [15:0] right_out_y;
  logic        [19:0] button_states;
  logic        [7:0]  dpad_states;
  logic               trigger_left;
  logic               trigger_right;

  modport source (
    output valid, left_out_x, left_out_y, right_out_x, right_out_y,
           button_states, dpad_states, trigger_left, trigger_right,
    input  ready
  );

  modport sink (
    input  valid, left_out_x, left_out_y, right_out_x, right_out_y,
           button_states, dpad_states, trigger_left, trigger_right,
    output ready
  );
endinterface

`default_nettype wire

[design/gamepad_input_conditioner_core.sv]
`default_nettype none

// One item is taken at a time: poll.ready is high only while idle, so a new item is
// not accepted until the result of the last one has been loaded for output. Work is
// paced by the single shared multiplier and the square root and divide steps (two
// bits per cycle) run for each stick in turn; a stick inside its deadzone skips
// its square root and divide steps.
// Reset clears all per-pad button state and loads the default deadzones.
module gamepad_input_conditioner_core import gic_pkg::*; #(
  parameter int PADS = GIC_PADS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gic_poll_if.sink         poll,
  gic_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic REG_LEFT_DZ  = 1'b0;
  localparam logic REG_RIGHT_DZ = 1'b1;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_PRESSED = 2'd1;
  localparam logic [1:0] ST_HELD    = 2'd2;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_HOLD = 3'b100
  } top_state_t;

  top_state_t  state;
  logic        go;
  logic        accept;
  logic        load;

  logic [14:0] left_dz;
  logic [14:0] right_dz;

  axis_t [3:0] axes;
  stick_req_t  req;
  eng_result_t eng_rsp;

  logic [1:0]  pad;
  logic [11:0] btn;
  logic [15:0] pov;

  logic [27:0] prev_states [PADS];
  logic [27:0] prev;
  logic [19:0] bs;
  logic [7:0]  ds;
  logic [9:0]  btn_main;
  logic [16:0] pov_mod;

  logic               res_valid;
  logic signed [15:0] out_lx;
  logic signed [15:0] out_ly;
  logic signed [15:0] out_rx;
  logic signed [15:0] out_ry;
  logic        [19:0] out_bs;
  logic        [7:0]  out_ds;
  logic               out_tl;
  logic               out_tr;

  // Saturated magnitude and final sign of one raw axis
  function automatic axis_t make_axis(input logic [15:0] v, input logic flip);
    logic [15:0] absv;
    axis_t       a;
    absv  = v[15] ? (~v + 16'd1) : v;
    a.mag = absv[15] ? AXIS_MAX : absv[14:0];
    a.neg = flip ? (!v[15] && (v != 16'h0000)) : v[15];
    return a;
  endfunction

  function automatic logic [1:0] track(input logic down, input logic [1:0] last);
    logic [1:0] st;
    if (!down) begin
      st = ST_NONE;
    end else begin
      st = (last == ST_NONE) ? ST_PRESSED : ST_HELD;
    end
    return st;
  endfunction

  // Hat lies strictly within a quarter turn of direction dir
  function automatic logic hat_near(input logic [16:0] a, input logic [16:0] dir);
    logic [16:0] diff;
    logic [16:0] gap;
    diff = a + FULL_TURN - dir;
    if (diff >= FULL_TURN) begin
      diff = diff - FULL_TURN;
    end
    gap = (diff > HALF_TURN) ? (FULL_TURN - diff) : diff;
    return gap < QUARTER_TURN;
  endfunction

  assign accept     = poll.valid && poll.ready;
  assign poll.ready = (state == T_IDLE);
  assign load       = (state == T_HOLD) && (!res_valid || result.ready);

  // Configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_LEFT_DZ:  prdata = {17'd0, left_dz};
      REG_RIGHT_DZ: prdata = {17'd0, right_dz};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dz  <= LEFT_DZ_RESET;
      right_dz <= RIGHT_DZ_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_LEFT_DZ:  left_dz  <= pwdata[14:0];
        REG_RIGHT_DZ: right_dz <= pwdata[14:0];
        default:      left_dz  <= left_dz;
      endcase
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (accept) begin
      pad     <= poll.pad_index;
      btn     <= poll.buttons;
      pov     <= poll.pov_angle;
      axes[0] <= make_axis(poll.left_x, 1'b0);
      axes[1] <= make_axis(poll.left_y, 1'b1);
      axes[2] <= make_axis(poll.right_x, 1'b0);
      axes[3] <= make_axis(poll.right_y, 1'b1);
    end
  end

  assign req = {axes, left_dz, right_dz};

  gic_stick_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (go),
    .req   (req),
    .rsp   (eng_rsp)
  );

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      go    <= 1'b0;
    end else begin
      go <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            go    <= 1'b1;
            state <= T_RUN;
          end
        end
        T_RUN: begin
          if (eng_rsp.done) begin
            state <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Previous states of this pad; a pad beyond the count reads as all released
  always_comb begin
    prev = '0;
    for (int i = 0; i < PADS; i++) begin
      if (32'(pad) == i) begin
        prev = prev_states[i];
      end
    end
  end

  assign btn_main = {btn[11:8], btn[5:0]};
  assign pov_mod  = ({1'b0, pov} >= FULL_TURN) ? ({1'b0, pov} - FULL_TURN) : {1'b0, pov};

  // Button and d-pad tracking
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      bs[2*k +: 2] = track(btn_main[k], prev[2*k +: 2]);
    end
    for (int k = 0; k < 4; k++) begin
      ds[2*k +: 2] = track((pov != POV_CENTERED) && hat_near(pov_mod, 17'(k * 9000)),
                           prev[20 + 2*k +: 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PADS; i++) begin
        prev_states[i] <= '0;
      end
    end else if (load) begin
      for (int i = 0; i < PADS; i++) begin
        if (32'(pad) == i) begin
          prev_states[i] <= {ds, bs};
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_lx <= signed'(eng_rsp.value[0]);
      out_ly <= signed'(eng_rsp.value[1]);
      out_rx <= signed'(eng_rsp.value[2]);
      out_ry <= signed'(eng_rsp.value[3]);
      out_bs <= bs;
      out_ds <= ds;
      out_tl <= btn[6];
      out_tr <= btn[7];
    end
  end

  assign result.valid         = res_valid;
  assign result.left_out_x    = out_lx;
  assign result.left_out_y    = out_ly;
  assign result.right_out_x   = out_rx;
  assign result.right_out_y   = out_ry;
  assign result.button_states = out_bs;
  assign result.dpad_states   = out_ds;
  assign result.trigger_left  = out_tl;
  assign result.trigger_right = out_tr;

endmodule

`default_nettype wire

[design/gic_stick_engine.sv]
`default_nettype none

module gic_stick_engine import gic_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire stick_req_t  req,
  output eng_result_t      rsp
);

  localparam int ROOT_CYCLES = 12;  // 24 root bits, two per cycle
  localparam int DIV_CYCLES  = 8;   // 16 quotient bits, two per cycle
  localparam logic [23:0] M_CAP = {1'b0, AXIS_MAX, 8'h00};

  typedef enum logic [5:0] {
    E_IDLE  = 6'b000001,
    E_PREP  = 6'b000010,
    E_ROOT  = 6'b000100,
    E_SCALE = 6'b001000,
    E_DIV   = 6'b010000,
    E_NEXT  = 6'b100000
  } eng_state_t;

  eng_state_t state;
  logic       sel;      // 0 left stick, 1 right stick
  logic       axis_y;   // 0 x axis, 1 y axis in the divide phase
  logic [3:0] cnt;
  logic       done;

  logic [30:0] s;
  logic [38:0] prod;
  logic [47:0] rad;
  logic [25:0] rem;
  logic [23:0] root;
  logic [38:0] den;
  logic [52:0] dvd;
  logic [53:0] dvs;
  logic [15:0] quo;
  logic [3:0][15:0] value;

  axis_t       cur_x;
  axis_t       cur_y;
  logic [14:0] dz;
  logic [23:0] mc;
  logic [23:0] span;
  logic [23:0] mul_a;
  logic [14:0] mul_b;
  logic        cur_neg;

  logic [27:0] root_t;
  logic [27:0] root_trial;
  logic [25:0] root_rem_n;
  logic [23:0] root_n;
  logic [47:0] rad_n;

  logic [52:0] dvd_n;
  logic [53:0] dvs_n;
  logic [15:0] quo_n;

  // Select the stick being worked on
  assign cur_x   = sel ? req.axis[2] : req.axis[0];
  assign cur_y   = sel ? req.axis[3] : req.axis[1];
  assign dz      = sel ? req.dz_right : req.dz_left;
  assign cur_neg = axis_y ? cur_y.neg : cur_x.neg;

  // Capped magnitude minus deadzone, both in Q.8
  assign mc   = (root > M_CAP) ? M_CAP : root;
  assign span = mc - {1'b0, dz, 8'h00};

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == E_PREP) begin
      if (cnt == 4'd0) begin
        mul_a = {9'd0, cur_x.mag};
        mul_b = cur_x.mag;
      end else if (cnt == 4'd1) begin
        mul_a = {9'd0, cur_y.mag};
        mul_b = cur_y.mag;
      end else if (cnt == 4'd2) begin
        mul_a = {9'd0, dz};
        mul_b = dz;
      end
    end else if (state == E_SCALE) begin
      if (cnt == 4'd0) begin
        mul_a = root;
        mul_b = AXIS_MAX - dz;
      end else begin
        mul_a = span;
        mul_b = axis_y ? cur_y.mag : cur_x.mag;
      end
    end
  end

  // Two restoring square root steps
  always_comb begin
    root_rem_n = rem;
    root_n     = root;
    rad_n      = rad;
    root_t     = '0;
    root_trial = '0;
    for (int i = 0; i < 2; i++) begin
      root_t     = {root_rem_n, rad_n[47:46]};
      root_trial = {2'b00, root_n, 2'b01};
      if (root_t >= root_trial) begin
        root_t = root_t - root_trial;
        root_n = {root_n[22:0], 1'b1};
      end else begin
        root_n = {root_n[22:0], 1'b0};
      end
      root_rem_n = root_t[25:0];
      rad_n      = {rad_n[45:0], 2'b00};
    end
  end

  // Two restoring division steps
  always_comb begin
    dvd_n = dvd;
    dvs_n = dvs;
    quo_n = quo;
    for (int i = 0; i < 2; i++) begin
      if ({1'b0, dvd_n} >= dvs_n) begin
        dvd_n = dvd_n - dvs_n[52:0];
        quo_n = {quo_n[14:0], 1'b1};
      end else begin
        quo_n = {quo_n[14:0], 1'b0};
      end
      dvs_n = {1'b0, dvs_n[53:1]};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      sel    <= 1'b0;
      axis_y <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            sel    <= 1'b0;
            axis_y <= 1'b0;
            cnt    <= '0;
            state  <= E_PREP;
          end
        end

        // Sum of squares, then deadzone test
        E_PREP: begin
          prod <= 39'(mul_a) * 39'(mul_b);
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd1) begin
            s <= prod[30:0];
          end else if (cnt == 4'd2) begin
            s <= s + prod[30:0];
          end else if (cnt == 4'd3) begin
            if ((dz == AXIS_MAX) || (s <= {1'b0, prod[29:0]})) begin
              value[{sel, 1'b0}] <= '0;
              value[{sel, 1'b1}] <= '0;
              state              <= E_NEXT;
            end else begin
              rad   <= {1'b0, s, 16'h0000};
              rem   <= '0;
              root  <= '0;
              cnt   <= '0;
              state <= E_ROOT;
            end
          end
        end

        // Magnitude in Q.8
        E_ROOT: begin
          rem  <= root_rem_n;
          root <= root_n;
          rad  <= rad_n;
          cnt  <= cnt + 4'd1;
          if (cnt == 4'(ROOT_CYCLES - 1)) begin
            cnt   <= '0;
            state <= E_SCALE;
          end
        end

        // Denominator (x axis pass only), then numerator of the current axis
        E_SCALE: begin
          prod <= 39'(mul_a) * 39'(mul_b);
          cnt  <= cnt + 4'd1;
          if ((cnt == 4'd1) && !axis_y) begin
            den <= prod;
          end
          if (cnt == 4'd2) begin
            dvd   <= {prod[37:0], 15'h0000} - {15'h0000, prod[37:0]};
            dvs   <= {den, 15'h0000};
            quo   <= '0;
            cnt   <= '0;
            state <= E_DIV;
          end
        end

        E_DIV: begin
          dvd <= dvd_n;
          dvs <= dvs_n;
          quo <= quo_n;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(DIV_CYCLES - 1)) begin
            value[{sel, axis_y}] <= cur_neg ? (16'd0 - quo_n) : quo_n;
            if (!axis_y) begin
              axis_y <= 1'b1;
              cnt    <= 4'd1;
              state  <= E_SCALE;
            end else begin
              state <= E_NEXT;
            end
          end
        end

        // Advance to the right stick or finish
        E_NEXT: begin
          if (!sel) begin
            sel    <= 1'b1;
            axis_y <= 1'b0;
            cnt    <= '0;
            state  <= E_PREP;
          end else begin
            done  <= 1'b1;
            state <= E_IDLE;
          end
        end

        default: state <= E_IDLE;
      endcase
    end
  end

  assign rsp = {done, value};

endmodule

`default_nettype wire
